[rtl/morse_pkg.sv]
package morse_pkg;

  localparam int unsigned DOT_W  = 16;
  localparam int unsigned DUR_W  = 19;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned BITS_W = 7;
  localparam int unsigned CNT_W  = 3;

  localparam logic [DOT_W-1:0]  DOT_TICKS_RESET = 16'd200;
  localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MARK,
    ST_GAP,
    ST_CLOSE,
    ST_SPACE,
    ST_BAD
  } state_t;

  typedef enum logic [1:0] {
    K_SYM,
    K_SPACE,
    K_BAD
  } kind_t;

  typedef enum logic [2:0] {
    P_MARK,
    P_GAP,
    P_CLOSE,
    P_SPACE,
    P_BAD
  } pulse_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    pulse_t pulse;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  cnt_zero;
    logic  cnt_one;
    logic  out_free;
  } dp_status_t;

  typedef struct packed {
    logic              found;
    logic [BITS_W-1:0] bits;
    logic [CNT_W-1:0]  len;
  } lookup_t;

  // Code word: high byte = elements (1 = dash, first element highest), low byte = count.
  function automatic lookup_t morse_lookup(input logic [CHAR_W-1:0] ch);
    logic [15:0] code;
    logic        hit;
    lookup_t     res;
    hit = 1'b1;
    case (ch)
      8'h21: code = 16'd11014;
      8'h22: code = 16'd4614;
      8'h24: code = 16'd2311;
      8'h26: code = 16'd2053;
      8'h27: code = 16'd7686;
      8'h28: code = 16'd5637;
      8'h29: code = 16'd11526;
      8'h2B: code = 16'd2565;
      8'h2C: code = 16'd13062;
      8'h2D: code = 16'd8454;
      8'h2E: code = 16'd5382;
      8'h2F: code = 16'd4613;
      8'h30: code = 16'd7941;
      8'h31: code = 16'd3845;
      8'h32: code = 16'd1797;
      8'h33: code = 16'd773;
      8'h34: code = 16'd261;
      8'h35: code = 16'd5;
      8'h36: code = 16'd4101;
      8'h37: code = 16'd6149;
      8'h38: code = 16'd7173;
      8'h39: code = 16'd7685;
      8'h3A: code = 16'd14342;
      8'h3B: code = 16'd10758;
      8'h3D: code = 16'd4357;
      8'h3F: code = 16'd3078;
      8'h40: code = 16'd6662;
      8'h41: code = 16'd258;
      8'h42: code = 16'd2052;
      8'h43: code = 16'd2564;
      8'h44: code = 16'd1027;
      8'h45: code = 16'd1;
      8'h46: code = 16'd516;
      8'h47: code = 16'd1539;
      8'h48: code = 16'd4;
      8'h49: code = 16'd2;
      8'h4A: code = 16'd1796;
      8'h4B: code = 16'd1283;
      8'h4C: code = 16'd1028;
      8'h4D: code = 16'd770;
      8'h4E: code = 16'd514;
      8'h4F: code = 16'd1795;
      8'h50: code = 16'd1540;
      8'h51: code = 16'd3332;
      8'h52: code = 16'd515;
      8'h53: code = 16'd3;
      8'h54: code = 16'd257;
      8'h55: code = 16'd259;
      8'h56: code = 16'd260;
      8'h57: code = 16'd771;
      8'h58: code = 16'd2308;
      8'h59: code = 16'd2820;
      8'h5A: code = 16'd3076;
      8'h5F: code = 16'd3334;
      default: begin
        code = 16'd0;
        hit  = 1'b0;
      end
    endcase
    res.found = hit;
    res.bits  = code[8 +: BITS_W];
    // element count saturates at seven
    res.len   = (code[7:0] > 8'd7) ? 3'd7 : code[CNT_W-1:0];
    return res;
  endfunction

endpackage

[rtl/morse_if.sv]
interface morse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface morse_out_if;
  logic        valid;
  logic        ready;
  logic        lamp_lit;
  logic [18:0] duration;
  logic        bad_char;
  logic        last_pulse;

  modport source (output valid, output lamp_lit, output duration, output bad_char,
                  output last_pulse, input ready);
  modport sink   (input valid, input lamp_lit, input duration, input bad_char,
                  input last_pulse, output ready);
endinterface

[rtl/morse_ctrl.sv]
module morse_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  morse_pkg::dp_status_t status,
  output morse_pkg::dp_cmd_t   cmd,
  output morse_pkg::state_t    cur_state
);
  import morse_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    cmd.pulse  = P_MARK;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        case (status.kind)
          K_SYM:   state_next = status.cnt_zero ? ST_CLOSE : ST_MARK;
          K_SPACE: state_next = ST_SPACE;
          default: state_next = ST_BAD;
        endcase
      end
      ST_MARK: begin
        cmd.pulse = P_MARK;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_GAP;
        end
      end
      ST_GAP: begin
        cmd.pulse = P_GAP;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.cnt_one ? ST_CLOSE : ST_MARK;
        end
      end
      ST_CLOSE: begin
        cmd.pulse = P_CLOSE;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SPACE: begin
        cmd.pulse = P_SPACE;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_BAD: begin
        cmd.pulse = P_BAD;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign cur_state = state;

endmodule

[rtl/morse_dp.sv]
module morse_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            character,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  morse_pkg::dp_cmd_t    cmd,
  output morse_pkg::dp_status_t status,
  morse_out_if.source           out_ch
);
  import morse_pkg::*;

  logic [DOT_W-1:0]  dot_ticks;
  logic [BITS_W-1:0] bits;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_idx;
  kind_t             kind;
  lookup_t           lk;
  logic              dash;
  logic [DUR_W-1:0]  dot1, dot2, dot3, dot6;

  logic              out_valid;
  logic              lamp_lit;
  logic [DUR_W-1:0]  duration;
  logic              bad_char;
  logic              last_pulse;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks <= DOT_TICKS_RESET;
    end else if (cfg_we) begin
      dot_ticks <= cfg_wdata;
    end
  end

  assign lk = morse_lookup(character);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bits <= lk.bits;
      cnt  <= lk.len;
      if (lk.found) begin
        kind <= K_SYM;
      end else if (character == CHAR_SPACE) begin
        kind <= K_SPACE;
      end else begin
        kind <= K_BAD;
      end
    end else if (cmd.emit && cmd.pulse == P_GAP) begin
      cnt <= cnt - 3'd1;
    end
  end

  assign cnt_idx = cnt - 3'd1;
  assign dash    = bits[cnt_idx];

  assign dot1 = {{(DUR_W-DOT_W){1'b0}}, dot_ticks};
  assign dot2 = dot1 << 1;
  assign dot3 = dot1 + dot2;
  assign dot6 = dot3 << 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.pulse)
        P_MARK: begin
          lamp_lit   <= 1'b1;
          duration   <= dash ? dot3 : dot1;
          bad_char   <= 1'b0;
          last_pulse <= 1'b0;
        end
        P_GAP: begin
          lamp_lit   <= 1'b0;
          duration   <= dot1;
          bad_char   <= 1'b0;
          last_pulse <= 1'b0;
        end
        P_CLOSE: begin
          lamp_lit   <= 1'b0;
          duration   <= dot2;
          bad_char   <= 1'b0;
          last_pulse <= 1'b1;
        end
        P_SPACE: begin
          lamp_lit   <= 1'b0;
          duration   <= dot6;
          bad_char   <= 1'b0;
          last_pulse <= 1'b1;
        end
        default: begin
          lamp_lit   <= 1'b0;
          duration   <= '0;
          bad_char   <= 1'b1;
          last_pulse <= 1'b1;
        end
      endcase
    end
  end

  assign status.kind     = kind;
  assign status.cnt_zero = (cnt == 3'd0);
  assign status.cnt_one  = (cnt == 3'd1);
  assign status.out_free = !out_valid || out_ch.ready;

  assign out_ch.valid      = out_valid;
  assign out_ch.lamp_lit   = lamp_lit;
  assign out_ch.duration   = duration;
  assign out_ch.bad_char   = bad_char;
  assign out_ch.last_pulse = last_pulse;

endmodule

[rtl/ascii_to_morse_pulse_encoder_top.sv]
// After a character transaction the sequencer passes the lookup state, then emits
// one pulse per cycle into a single output register unless the output stalls.
// Reset (rst, synchronous, active high): sequencer idle, output empty, dot_ticks = 200.
// A new character is taken only after the previous one's last pulse is registered.
module ascii_to_morse_pulse_encoder_top (
  input  logic        clk,
  input  logic        rst,
  morse_in_if.sink    in_ch,
  morse_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import morse_pkg::*;

  // Controller <-> datapath handshake
  dp_cmd_t    cmd;
  dp_status_t status;
  state_t     state;
  logic       in_ready;

  // Sequencer: walks idle -> lookup -> (mark, gap)* -> close, or space / bad.
  morse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd),
    .cur_state (state)
  );

  // Datapath: table lookup, element down-counter, dot multiples, output register.
  morse_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .character (in_ch.character),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_ch    (out_ch)
  );

  assign in_ch.ready = in_ready;

`ifndef NO_ASSERTIONS
  // One character in flight: after a transaction the input is closed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a character is in flight");

  // A bad character is a single closing result with zero length.
  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.bad_char |-> out_ch.last_pulse && out_ch.duration == '0
      && !out_ch.lamp_lit)
    else $error("malformed bad-character result");

  // A mark is never the final pulse of a character.
  a_mark_not_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.lamp_lit |-> !out_ch.last_pulse)
    else $error("lamp pulse flagged as last");

  // Emission only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten");

  // Sequencer returns to idle only after the last pulse is emitted.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE ##1 state == ST_IDLE |-> out_ch.valid && out_ch.last_pulse)
    else $error("sequencer idle without final pulse");
`endif

endmodule
